// ===== design/sgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, constants and the ramp function for the sensor to rgb gradient block.
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned OFFSET_W = 10;

    localparam logic [SAMPLE_W-1:0] DEADBAND_RESET = 12'd10;

    // region bounds of the five ramps
    localparam logic [SAMPLE_W-1:0] LOW_CLAMP  = 12'd242;
    localparam logic [SAMPLE_W-1:0] RAMP1_END  = 12'd813;
    localparam logic [SAMPLE_W-1:0] RAMP2_END  = 12'd1385;
    localparam logic [SAMPLE_W-1:0] RAMP3_BASE = 12'd1386;
    localparam logic [SAMPLE_W-1:0] RAMP3_END  = 12'd1957;
    localparam logic [SAMPLE_W-1:0] RAMP4_END  = 12'd2529;
    localparam logic [SAMPLE_W-1:0] RAMP5_BASE = 12'd2530;
    localparam logic [SAMPLE_W-1:0] HIGH_CLAMP = 12'd3100;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_OFF  = 8'd0;

    // 255 * ceil(2^27 / 571): floor(off*this >> 27) == floor(255*off/571) for off <= 571
    localparam int unsigned RAMP_SHIFT = 27;
    localparam logic [25:0] RAMP_MULT  = 26'd59939790;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } t_rgb;

    function automatic logic [DUTY_W-1:0] ramp(input logic [OFFSET_W-1:0] off);
        logic [35:0] prod;
        prod = 36'(off) * 36'(RAMP_MULT);
        return prod[RAMP_SHIFT+DUTY_W-1:RAMP_SHIFT];
    endfunction

endpackage

// ===== design/sgr_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_map
// Maps one sample onto the five-ramp colour gradient with clamps.
// ----------------------------------------------------------------------------
module sgr_map (
    input  logic [sgr_pkg::SAMPLE_W-1:0] i_sample,
    output sgr_pkg::t_rgb                o_rgb
);
    import sgr_pkg::*;

    logic [SAMPLE_W-1:0] diff;
    logic [DUTY_W-1:0]   level;

    // one shared ramp: pick the offset of the region the sample falls in
    always_comb begin
        if (i_sample <= RAMP1_END) begin
            diff = i_sample - LOW_CLAMP;
        end else if (i_sample <= RAMP2_END) begin
            diff = RAMP2_END - i_sample;
        end else if (i_sample <= RAMP3_END) begin
            diff = i_sample - RAMP3_BASE;
        end else if (i_sample <= RAMP4_END) begin
            diff = RAMP4_END - i_sample;
        end else begin
            diff = i_sample - RAMP5_BASE;
        end
    end

    assign level = ramp(diff[OFFSET_W-1:0]);

    always_comb begin
        if (i_sample < LOW_CLAMP) begin
            o_rgb = '{red: DUTY_FULL, green: DUTY_OFF, blue: DUTY_OFF};
        end else if (i_sample <= RAMP1_END) begin
            o_rgb = '{red: DUTY_FULL, green: level, blue: DUTY_OFF};
        end else if (i_sample <= RAMP2_END) begin
            o_rgb = '{red: level, green: DUTY_FULL, blue: DUTY_OFF};
        end else if (i_sample <= RAMP3_END) begin
            o_rgb = '{red: DUTY_OFF, green: DUTY_FULL, blue: level};
        end else if (i_sample <= RAMP4_END) begin
            o_rgb = '{red: DUTY_OFF, green: level, blue: DUTY_FULL};
        end else if (i_sample <= HIGH_CLAMP) begin
            o_rgb = '{red: level, green: DUTY_OFF, blue: DUTY_FULL};
        end else begin
            o_rgb = '{red: DUTY_FULL, green: DUTY_OFF, blue: DUTY_FULL};
        end
    end

endmodule

// ===== design/sensor_to_rgb_gradient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_to_rgb_gradient
// Temperature sample to rgb pwm duty mapping with a deadband.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while o_ready is high and returns one result
// word per sample through the input and result registers. A sample that differs
// from the held sample by at least the deadband replaces it and recomputes the
// held duties; every result carries the held duties and an updated flag. The held
// sample is compared and rewritten in the same stage, so consecutive samples see
// each other's effect with no gap. The deadband register resets to 10; the user
// must write it only while the block is idle, which the block does not enforce.
module sensor_to_rgb_gradient (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_deadband_we,
    input  logic [sgr_pkg::SAMPLE_W-1:0] i_deadband,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [sgr_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sgr_pkg::DUTY_W-1:0]   o_red_duty,
    output logic [sgr_pkg::DUTY_W-1:0]   o_green_duty,
    output logic [sgr_pkg::DUTY_W-1:0]   o_blue_duty,
    output logic                         o_updated
);
    import sgr_pkg::*;

    logic [SAMPLE_W-1:0] r_deadband;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic [SAMPLE_W-1:0] r_held;
    t_rgb                r_level;
    logic                r_out_valid;
    t_rgb                r_out_rgb;
    logic                r_out_updated;

    logic                out_load;
    logic                in_take;
    logic [SAMPLE_W-1:0] sample_gap;
    logic                pass;
    t_rgb                mapped;

    assign out_load = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || out_load;
    assign in_take  = i_valid && o_ready;

    assign sample_gap = (r_in_sample >= r_held) ? (r_in_sample - r_held)
                                                : (r_held - r_in_sample);
    assign pass = (sample_gap >= r_deadband);

    sgr_map u_map (
        .i_sample (r_in_sample),
        .o_rgb    (mapped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RESET;
        end else if (i_deadband_we) begin
            r_deadband <= i_deadband;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_sample;
        end
    end

    // held state moves with the word entering the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_level <= '0;
        end else if (out_load && pass) begin
            r_held  <= r_in_sample;
            r_level <= mapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rgb     <= pass ? mapped : r_level;
            r_out_updated <= pass;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red_duty   = r_out_rgb.red;
    assign o_green_duty = r_out_rgb.green;
    assign o_blue_duty  = r_out_rgb.blue;
    assign o_updated    = r_out_updated;

endmodule

// ===== dv/tb_sensor_to_rgb_gradient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_to_rgb_gradient
// Self-checking bench for the sensor to rgb gradient block.
// ----------------------------------------------------------------------------
// Drives sample words through the valid/ready input and collects duty words
// from the output with random stalls on both sides. A scoreboard keeps its own
// copy of the held sample, held colour and deadband. It predicts the duties and
// the updated flag of every accepted sample, and compares them in order with
// the words that come back. A short directed pass covers the region edges, both
// clamps, a zero deadband and a full-scale deadband. It is followed by random
// phases under several deadband settings. The last phase runs with no idling.
// ----------------------------------------------------------------------------
module tb_sensor_to_rgb_gradient;

    import sgr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RAMP_SPAN    = 571;
    localparam int unsigned RAMP_TOP     = 255;
    localparam int unsigned PHASE_COUNT  = 7;
    localparam int unsigned PHASE_WORDS  = 280;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        t_rgb rgb;
        logic updated;
    } t_duty_word;

    class duty_scoreboard;
        logic [SAMPLE_W-1:0] deadband;
        logic [SAMPLE_W-1:0] held;
        t_rgb                held_rgb;
        t_duty_word          awaited[$];
        int unsigned         errors;

        function new();
            deadband = DEADBAND_RESET;
            held     = '0;
            held_rgb = '{DUTY_OFF, DUTY_OFF, DUTY_OFF};
            errors   = 0;
        endfunction

        function void set_deadband(logic [SAMPLE_W-1:0] v);
            deadband = v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [DUTY_W-1:0] slope(int unsigned off);
            return DUTY_W'((RAMP_TOP * off) / RAMP_SPAN);
        endfunction

        function t_rgb colour_of(logic [SAMPLE_W-1:0] s);
            t_rgb c;
            if (s < LOW_CLAMP) begin
                c = '{DUTY_FULL, DUTY_OFF, DUTY_OFF};
            end else if (s <= RAMP1_END) begin
                c = '{DUTY_FULL, slope(s - LOW_CLAMP), DUTY_OFF};
            end else if (s <= RAMP2_END) begin
                c = '{slope(RAMP2_END - s), DUTY_FULL, DUTY_OFF};
            end else if (s <= RAMP3_END) begin
                c = '{DUTY_OFF, DUTY_FULL, slope(s - RAMP3_BASE)};
            end else if (s <= RAMP4_END) begin
                c = '{DUTY_OFF, slope(RAMP4_END - s), DUTY_FULL};
            end else if (s <= HIGH_CLAMP) begin
                c = '{slope(s - RAMP5_BASE), DUTY_OFF, DUTY_FULL};
            end else begin
                c = '{DUTY_FULL, DUTY_OFF, DUTY_FULL};
            end
            return c;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            t_duty_word w;
            logic [SAMPLE_W-1:0] gap;
            gap = (s >= held) ? s - held : held - s;
            w.updated = (gap >= deadband);
            if (w.updated) begin
                held     = s;
                held_rgb = colour_of(s);
            end
            w.rgb = held_rgb;
            awaited.push_back(w);
        endfunction

        function void check_result(logic [DUTY_W-1:0] r, logic [DUTY_W-1:0] g,
                                   logic [DUTY_W-1:0] b, logic u);
            t_duty_word w;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected word: r=%0d g=%0d b=%0d upd=%0b", r, g, b, u);
                return;
            end
            w = awaited.pop_front();
            if (r !== w.rgb.red || g !== w.rgb.green || b !== w.rgb.blue
                    || u !== w.updated) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: exp rgb %0d/%0d/%0d upd %0b, got %0d/%0d/%0d upd %0b",
                             w.rgb.red, w.rgb.green, w.rgb.blue, w.updated, r, g, b, u);
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_deadband_we = 1'b0;
    logic [SAMPLE_W-1:0] i_deadband    = '0;
    logic                i_valid       = 1'b0;
    logic [SAMPLE_W-1:0] i_sample      = '0;
    logic                i_ready       = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [DUTY_W-1:0]   o_red_duty;
    logic [DUTY_W-1:0]   o_green_duty;
    logic [DUTY_W-1:0]   o_blue_duty;
    logic                o_updated;

    duty_scoreboard sb;
    bit             gaps_on  = 1'b1;
    bit             stall_on = 1'b1;
    int unsigned    ready_hold  = 0;
    int unsigned    cycle_count = 0;

    // region edges and their neighbors
    logic [SAMPLE_W-1:0] edge_points[24] = '{
        12'd0, 12'd241, 12'd242, 12'd243, 12'd812, 12'd813, 12'd814, 12'd815,
        12'd1384, 12'd1385, 12'd1386, 12'd1387, 12'd1956, 12'd1957, 12'd1958,
        12'd1959, 12'd2528, 12'd2529, 12'd2530, 12'd2531, 12'd3099, 12'd3100,
        12'd3101, 12'd4095
    };

    // both clamps, every ramp end, then same-colour updates: two at the high clamp, one at the low
    logic [SAMPLE_W-1:0] opening_run[19] = '{
        12'd0, 12'd5, 12'd241, 12'd242, 12'd252, 12'd813, 12'd814, 12'd1385,
        12'd1386, 12'd1957, 12'd1958, 12'd2529, 12'd2530, 12'd3100, 12'd3101,
        12'd4095, 12'd3200, 12'd0, 12'd100
    };

    sensor_to_rgb_gradient dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_deadband_we (i_deadband_we),
        .i_deadband    (i_deadband),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red_duty    (o_red_duty),
        .o_green_duty  (o_green_duty),
        .o_blue_duty   (o_blue_duty),
        .o_updated     (o_updated)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side back-pressure in bursts of random length
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if (stall_on && $urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(0, 15);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_red_duty, o_green_duty, o_blue_duty, o_updated);
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(s);
    endtask

    task automatic pause_sender(input int unsigned n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_deadband(input logic [SAMPLE_W-1:0] v);
        i_deadband_we <= 1'b1;
        i_deadband    <= v;
        @(posedge i_clk);
        sb.set_deadband(v);
        i_deadband_we <= 1'b0;
    endtask

    // mix of uniform words, words right at the deadband edge, region edges
    // and small moves around the held sample
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned kind;
        int          d;
        int          s;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            s = $urandom_range(0, 4095);
        end else if (kind < 65) begin
            d = int'(sb.deadband) + int'($urandom_range(0, 2)) - 1;
            s = $urandom_range(0, 1) ? int'(sb.held) + d : int'(sb.held) - d;
        end else if (kind < 85) begin
            s = edge_points[$urandom_range(0, 23)];
        end else begin
            s = int'(sb.held) + int'($urandom_range(0, 40)) - 20;
        end
        if (s < 0 || s > 4095)
            s = $urandom_range(0, 4095);
        return SAMPLE_W'(s);
    endfunction

    initial begin
        logic [SAMPLE_W-1:0] band_plan[PHASE_COUNT];
        int unsigned ph;

        sb = new();
        band_plan = '{12'd0, 12'd1, 12'd4095, 12'd0, 12'd64, 12'd0, 12'd10};
        band_plan[3] = SAMPLE_W'($urandom_range(2, 4094));
        band_plan[5] = SAMPLE_W'($urandom_range(2, 200));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_run[k])
            send_sample(opening_run[k]);
        settle();

        // zero deadband: repeats still count as updates
        write_deadband(12'd0);
        send_sample(12'd100);
        send_sample(12'd101);
        send_sample(12'd0);
        settle();

        // full-scale deadband: only a jump between 0 and 4095 passes
        write_deadband(12'd4095);
        send_sample(12'd4094);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd1);
        settle();

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            write_deadband(band_plan[ph]);
            if (ph == PHASE_COUNT - 1) begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            repeat (PHASE_WORDS) begin
                if (gaps_on && $urandom_range(0, 7) == 0)
                    pause_sender($urandom_range(1, 16));
                send_sample(pick_sample());
            end
            settle();
        end

        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
